/* hdl/coupled_renyi_map_generator_top_defines.svh */
// assertion macros used by the checker file
`ifndef COUPLED_RENYI_MAP_GENERATOR_TOP_DEFINES_SVH
`define COUPLED_RENYI_MAP_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define CRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crm check failed");

// next-cycle implication, quiet while reset is held
`define CRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crm check failed");

// next-cycle implication that also covers the reset cycles
`define CRM_ASSERT_ALWAYS_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("crm check failed");

`endif

/* hdl/crm_pkg.sv */
`default_nettype none

package crm_pkg;

    localparam int WORD_BITS      = 32;
    localparam int LANES          = 4;
    localparam int LANE_BITS      = $clog2(LANES);
    localparam int REG_INDEX_BITS = 3;
    localparam int SHIFT          = 9;
    localparam int MASK_BITS      = 5;

    typedef logic [WORD_BITS-1:0]      t_word;
    typedef t_word [LANES-1:0]         t_lane_vec;
    typedef logic [REG_INDEX_BITS-1:0] t_reg_index;

    localparam t_word LOW_MASK = t_word'((64'd1 << MASK_BITS) - 64'd1);

    // register map: multipliers first, then seeds
    localparam t_reg_index REG_MULTIPLIER_0 = 3'd0;
    localparam t_reg_index REG_SEED_0       = 3'd4;

    localparam t_lane_vec MULT_RESET = {32'd65537, 32'd524287, 32'd104729, 32'd131071};
    localparam t_lane_vec SEED_RESET = {32'd823, 32'd227, 32'd769, 32'd653};

    typedef struct packed {
        logic restart;
    } t_in;

    typedef struct packed {
        t_word word_0;
        t_word word_1;
        t_word word_2;
        t_word word_3;
        t_word mix_word;
    } t_out;

    typedef struct packed {
        t_reg_index reg_index;
        t_word      reg_value;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/crm_stream_if.sv */
`default_nettype none

interface crm_in_if;
    logic        valid;
    logic        ready;
    crm_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crm_out_if;
    logic          valid;
    logic          ready;
    crm_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crm_cfg_if;
    logic          valid;
    logic          ready;
    crm_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/crm_lane.sv */
`default_nettype none

module crm_lane (
    input  wire logic           i_restart,
    input  wire crm_pkg::t_word i_state,
    input  wire crm_pkg::t_word i_seed,
    input  wire crm_pkg::t_word i_mult,
    input  wire crm_pkg::t_word i_mix,
    output crm_pkg::t_word      o_next
);

    crm_pkg::t_word src;
    crm_pkg::t_word prod;
    crm_pkg::t_word mapped;

    // renyi map on either the seed or the running lane value
    assign src    = i_restart ? i_seed : i_state;
    assign prod   = src * i_mult;
    assign mapped = prod + (src >> crm_pkg::SHIFT);

    always_comb begin
        if (i_restart) begin
            o_next = mapped;
        end else begin
            o_next = (~crm_pkg::LOW_MASK) ^ (mapped + crm_pkg::LOW_MASK) ^ i_mix;
        end
    end

endmodule

`default_nettype wire

/* hdl/crm_merge.sv */
`default_nettype none

module crm_merge (
    input  wire crm_pkg::t_lane_vec i_lanes,
    output crm_pkg::t_out           o_word
);

    crm_pkg::t_word mix;

    always_comb begin
        mix = '0;
        for (int i = 0; i < crm_pkg::LANES; i++) begin
            mix = mix ^ i_lanes[i];
        end
    end

    assign o_word.word_0   = i_lanes[0];
    assign o_word.word_1   = i_lanes[1];
    assign o_word.word_2   = i_lanes[2];
    assign o_word.word_3   = i_lanes[3];
    assign o_word.mix_word = mix;

endmodule

`default_nettype wire

/* hdl/coupled_renyi_map_generator_top.sv */
// Coupled Renyi map generator: four 32-bit lanes, each running
// f(x) = x*a + (x >> 9) mod 2^32, coupled through a shared mix word. A word
// with restart=1 seeds every lane with f(seed); a word with restart=0 runs one
// round, new = ~31 ^ (f(x) + 31) ^ mix, and every word yields one result of
// four lane values plus their XOR. Throughput is one word per clock unless the
// output stalls: lane state and mix are registered, and each lane's 32x32
// multiply plus the four-way XOR form the register-to-register loop that sets
// the clock. A result is valid in the cycle after its word is accepted; an
// output register lets the next word in while the last result is still being
// taken. Multipliers sit at indexes 0..3 and seeds at 4..7 of the config port,
// which is always ready; write them only while no word is in flight.
`default_nettype none

module coupled_renyi_map_generator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crm_in_if.sink    i_in,
    crm_out_if.source o_out,
    crm_cfg_if.sink   i_cfg
);

    // config registers
    crm_pkg::t_lane_vec r_mult;
    crm_pkg::t_lane_vec r_seed;

    // generator state: lane values and the mix word from the last round
    crm_pkg::t_lane_vec r_lane;
    crm_pkg::t_word     r_mix;

    // output register
    logic          r_out_valid;
    logic          n_out_valid;
    crm_pkg::t_out r_out_data;

    crm_pkg::t_lane_vec next_lane;
    crm_pkg::t_out      merged;
    logic               in_acc;
    logic               cfg_acc;
    logic               cfg_is_mult;
    crm_pkg::t_reg_index cfg_off;
    logic [crm_pkg::LANE_BITS-1:0] cfg_lane;

    // take a new word whenever the output slot is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    // register index decode: below the seed block means a multiplier
    assign cfg_is_mult = i_cfg.data.reg_index < crm_pkg::REG_SEED_0;
    assign cfg_off     = cfg_is_mult ? (i_cfg.data.reg_index - crm_pkg::REG_MULTIPLIER_0)
                                     : (i_cfg.data.reg_index - crm_pkg::REG_SEED_0);
    assign cfg_lane    = cfg_off[crm_pkg::LANE_BITS-1:0];

    // one map unit per lane
    for (genvar g = 0; g < crm_pkg::LANES; g++) begin : g_lane
        crm_lane u_lane (
            .i_restart (i_in.data.restart),
            .i_state   (r_lane[g]),
            .i_seed    (r_seed[g]),
            .i_mult    (r_mult[g]),
            .i_mix     (r_mix),
            .o_next    (next_lane[g])
        );
    end

    // fold the lanes into the result word and the new mix
    crm_merge u_merge (
        .i_lanes (next_lane),
        .o_word  (merged)
    );

    assign n_out_valid = in_acc || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult      <= crm_pkg::MULT_RESET;
            r_seed      <= crm_pkg::SEED_RESET;
            r_lane      <= '0;
            r_mix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_lane <= next_lane;
                r_mix  <= merged.mix_word;
            end
            if (cfg_acc) begin
                if (cfg_is_mult) begin
                    r_mult[cfg_lane] <= i_cfg.data.reg_value;
                end else begin
                    r_seed[cfg_lane] <= i_cfg.data.reg_value;
                end
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= merged;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

`default_nettype wire

/* hdl/crm_checker.sv */
`default_nettype none
`include "coupled_renyi_map_generator_top_defines.svh"

module crm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire crm_pkg::t_out i_out_data
);

    // a result waits until it is taken
    `CRM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // an accepted word shows up as a result on the next cycle
    `CRM_ASSERT_NEXT(a_in_to_out, i_in_valid && i_in_ready, i_out_valid)

    // the mix word is always the xor of the four lane words
    `CRM_ASSERT_IMP(a_mix_xor, i_out_valid, i_out_data.mix_word == (i_out_data.word_0 ^
        i_out_data.word_1 ^ i_out_data.word_2 ^ i_out_data.word_3))

    // an empty output slot never blocks the input
    `CRM_ASSERT_IMP(a_ready_empty, !i_out_valid, i_in_ready)

    // no result straight out of reset
    `CRM_ASSERT_ALWAYS_NEXT(a_reset_quiet, !i_rst_n, !i_out_valid)

endmodule

bind coupled_renyi_map_generator_top crm_checker u_crm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
